// ===== src/fcsm_pkg.sv =====
// shared widths, types and helpers for the fan curve speed map
package fcsm_pkg;

    localparam int TEMP_WIDTH      = 8;
    localparam int SPEED_WIDTH     = 16;
    localparam int BP_COUNT        = 5;
    localparam int BP_WIDTH        = BP_COUNT * TEMP_WIDTH;
    localparam int CFG_DATA_WIDTH  = (BP_WIDTH > SPEED_WIDTH) ? BP_WIDTH : SPEED_WIDTH;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int NUM_WIDTH       = SPEED_WIDTH + TEMP_WIDTH + 2;
    localparam int DEN_WIDTH       = SPEED_WIDTH + TEMP_WIDTH;
    localparam int CMP_WIDTH       = ((TEMP_WIDTH > SPEED_WIDTH) ? TEMP_WIDTH : SPEED_WIDTH) + 2;

    typedef logic [TEMP_WIDTH-1:0]  temp_t;
    typedef logic [SPEED_WIDTH-1:0] speed_t;

    localparam speed_t SPEED_MAX  = '1;
    localparam speed_t STEP_RESET = speed_t'(100);

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_ALLOW_FAN_OFF   = 3'd0,
        REG_BREAKPOINTS     = 3'd1,
        REG_MIN_USABLE      = 3'd2,
        REG_SPEED_AT_START  = 3'd3,
        REG_SPEED_AT_MID    = 3'd4,
        REG_SPEED_AT_END    = 3'd5,
        REG_FULL_SPEED      = 3'd6,
        REG_SPEED_STEP      = 3'd7
    } cfg_reg_e;

    typedef struct packed {
        logic                allow_fan_off;
        logic [BP_WIDTH-1:0] temperature_breakpoints;
        speed_t              min_usable_speed;
        speed_t              speed_at_start;
        speed_t              speed_at_mid;
        speed_t              speed_at_end;
        speed_t              full_speed;
        speed_t              speed_step;
    } cfg_t;

    // dividend and divisor for one item, or a value that skips the division
    typedef struct packed {
        logic                 direct;
        speed_t               dval;
        logic                 up;
        logic [NUM_WIDTH-1:0] num;
        logic [DEN_WIDTH-1:0] den;
    } front_t;

    typedef struct packed {
        logic                 direct;
        speed_t               dval;
        logic                 up;
        logic [NUM_WIDTH-1:0] rem;
        logic [DEN_WIDTH-1:0] den;
        speed_t               quo;
    } div_stage_t;

    typedef struct packed {
        logic   direct;
        speed_t dval;
        logic   up;
        logic   rem_nz;
        speed_t quo;
    } div_t;

    function automatic speed_t eff_step(speed_t s);
        return (s == '0) ? speed_t'(1) : s;
    endfunction

endpackage

// ===== src/fcsm_if.sv =====
// valid/ready channels for temperature, fan speed and register writes
interface fcsm_temp_if;
    logic                  valid;
    logic                  ready;
    fcsm_pkg::temp_t       temperature;
    modport source (output valid, output temperature, input ready);
    modport sink (input valid, input temperature, output ready);
endinterface

interface fcsm_speed_if;
    logic                  valid;
    logic                  ready;
    fcsm_pkg::speed_t      fan_speed;
    modport source (output valid, output fan_speed, input ready);
    modport sink (input valid, input fan_speed, output ready);
endinterface

interface fcsm_cfg_if;
    logic                                   valid;
    logic                                   ready;
    logic [fcsm_pkg::CFG_INDEX_WIDTH-1:0]   index;
    logic [fcsm_pkg::CFG_DATA_WIDTH-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/fcsm_cfg_regs.sv =====
// configuration register file
module fcsm_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    fcsm_cfg_if.sink        cfg,
    output fcsm_pkg::cfg_t  regs
);

    fcsm_pkg::cfg_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '{
                allow_fan_off:           1'b0,
                temperature_breakpoints: '0,
                min_usable_speed:        '0,
                speed_at_start:          '0,
                speed_at_mid:            '0,
                speed_at_end:            '0,
                full_speed:              '0,
                speed_step:              fcsm_pkg::STEP_RESET
            };
        end
        else if (cfg.valid)
        begin
            unique case (fcsm_pkg::cfg_reg_e'(cfg.index))
                fcsm_pkg::REG_ALLOW_FAN_OFF:
                    regs_reg.allow_fan_off <= cfg.data[0];
                fcsm_pkg::REG_BREAKPOINTS:
                    regs_reg.temperature_breakpoints <= cfg.data[fcsm_pkg::BP_WIDTH-1:0];
                fcsm_pkg::REG_MIN_USABLE:
                    regs_reg.min_usable_speed <= cfg.data[fcsm_pkg::SPEED_WIDTH-1:0];
                fcsm_pkg::REG_SPEED_AT_START:
                    regs_reg.speed_at_start <= cfg.data[fcsm_pkg::SPEED_WIDTH-1:0];
                fcsm_pkg::REG_SPEED_AT_MID:
                    regs_reg.speed_at_mid <= cfg.data[fcsm_pkg::SPEED_WIDTH-1:0];
                fcsm_pkg::REG_SPEED_AT_END:
                    regs_reg.speed_at_end <= cfg.data[fcsm_pkg::SPEED_WIDTH-1:0];
                fcsm_pkg::REG_FULL_SPEED:
                    regs_reg.full_speed <= cfg.data[fcsm_pkg::SPEED_WIDTH-1:0];
                fcsm_pkg::REG_SPEED_STEP:
                    regs_reg.speed_step <= cfg.data[fcsm_pkg::SPEED_WIDTH-1:0];
                default:
                    regs_reg <= regs_reg;
            endcase
        end
    end

endmodule

// ===== src/fcsm_front.sv =====
// segment select, products and dividend sum: three pipeline stages
module fcsm_front (
    input  logic              clk,
    input  logic              rst_n,
    input  fcsm_pkg::cfg_t    cfg,
    fcsm_temp_if.sink         sample,
    output logic              out_valid,
    output fcsm_pkg::front_t  out_pl,
    input  logic              out_ready
);

    typedef struct packed {
        logic                              direct;
        fcsm_pkg::speed_t                  dval;
        logic                              up;
        fcsm_pkg::speed_t                  ya;
        fcsm_pkg::temp_t                   dxa;
        logic [fcsm_pkg::SPEED_WIDTH:0]    dy;
        logic [fcsm_pkg::TEMP_WIDTH:0]     xrel;
    } sel_t;

    typedef struct packed {
        logic                                                   direct;
        fcsm_pkg::speed_t                                       dval;
        logic                                                   up;
        logic [fcsm_pkg::SPEED_WIDTH+fcsm_pkg::TEMP_WIDTH-1:0]  p_ya;
        logic [fcsm_pkg::SPEED_WIDTH+fcsm_pkg::TEMP_WIDTH+1:0]  p_dy;
        logic [fcsm_pkg::DEN_WIDTH-1:0]                         den;
    } prod_t;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic move1, move2, move3;
    sel_t             s1_reg, s1_next;
    prod_t            s2_reg, s2_next;
    fcsm_pkg::front_t s3_reg, s3_next;

    fcsm_pkg::temp_t  t, t0, t1, t2, t3, t4, xa, xb, x;
    fcsm_pkg::speed_t ya, yb;
    logic signed [fcsm_pkg::TEMP_WIDTH:0]  dx, xrel;
    logic [fcsm_pkg::TEMP_WIDTH:0]         dx_mag;
    logic signed [fcsm_pkg::SPEED_WIDTH:0] dy, dy_half;
    logic signed [fcsm_pkg::CMP_WIDTH-1:0] x_cmp, half_cmp;
    logic signed [fcsm_pkg::SPEED_WIDTH+fcsm_pkg::TEMP_WIDTH+2:0] num_full;

    // a stage moves when it is empty or its successor moves
    assign move3        = !s3_valid_reg || out_ready;
    assign move2        = !s2_valid_reg || move3;
    assign move1        = !s1_valid_reg || move2;
    assign sample.ready = move1;
    assign out_valid    = s3_valid_reg;
    assign out_pl       = s3_reg;

    // stage 1: pick the curve region and the segment end points
    always_comb
    begin
        t  = sample.temperature;
        t0 = cfg.temperature_breakpoints[0*fcsm_pkg::TEMP_WIDTH +: fcsm_pkg::TEMP_WIDTH];
        t1 = cfg.temperature_breakpoints[1*fcsm_pkg::TEMP_WIDTH +: fcsm_pkg::TEMP_WIDTH];
        t2 = cfg.temperature_breakpoints[2*fcsm_pkg::TEMP_WIDTH +: fcsm_pkg::TEMP_WIDTH];
        t3 = cfg.temperature_breakpoints[3*fcsm_pkg::TEMP_WIDTH +: fcsm_pkg::TEMP_WIDTH];
        t4 = cfg.temperature_breakpoints[4*fcsm_pkg::TEMP_WIDTH +: fcsm_pkg::TEMP_WIDTH];

        s1_next.direct = 1'b1;
        s1_next.dval   = '0;
        xa = t1;
        xb = t2;
        ya = cfg.speed_at_start;
        yb = cfg.speed_at_mid;
        x  = t;

        if (t < t0 && cfg.allow_fan_off)
            s1_next.dval = '0;
        else if (t < t1 || (t < t0 && t == t1))
            s1_next.dval = cfg.min_usable_speed;
        else if (t <= t2)
        begin
            if (t == t1)
                s1_next.dval = cfg.speed_at_start;
            else if (t == t2)
                s1_next.dval = cfg.speed_at_mid;
            else
                s1_next.direct = 1'b0;
        end
        else if (t < t4)
        begin
            xa = t2;
            xb = t3;
            ya = cfg.speed_at_mid;
            yb = cfg.speed_at_end;
            x  = (t > t3) ? t3 : t;
            // zero-width segment gives its end speed as is
            if (t3 == t2)
                s1_next.dval = cfg.speed_at_end;
            else
                s1_next.direct = 1'b0;
        end
        else
            s1_next.dval = cfg.full_speed;

        dx   = $signed({1'b0, xb}) - $signed({1'b0, xa});
        xrel = $signed({1'b0, x}) - $signed({1'b0, xa});
        dy   = $signed({1'b0, yb}) - $signed({1'b0, ya});

        // half of dy, truncated toward zero
        dy_half  = (dy + $signed({{fcsm_pkg::SPEED_WIDTH{1'b0}}, dy[fcsm_pkg::SPEED_WIDTH]})) >>> 1;
        x_cmp    = $signed(fcsm_pkg::CMP_WIDTH'(x));
        half_cmp = fcsm_pkg::CMP_WIDTH'(dy_half);
        s1_next.up = x_cmp > half_cmp;

        // reversed segment: flip signs so the divisor stays positive
        dx_mag        = dx[fcsm_pkg::TEMP_WIDTH] ? -dx : dx;
        s1_next.dxa   = dx_mag[fcsm_pkg::TEMP_WIDTH-1:0];
        s1_next.xrel  = dx[fcsm_pkg::TEMP_WIDTH] ? -xrel : xrel;
        s1_next.dy    = dy;
        s1_next.ya    = ya;
    end

    // stage 2: the three products
    always_comb
    begin
        s2_next.direct = s1_reg.direct;
        s2_next.dval   = s1_reg.dval;
        s2_next.up     = s1_reg.up;
        s2_next.p_ya   = s1_reg.ya * s1_reg.dxa;
        s2_next.p_dy   = $signed(s1_reg.dy) * $signed(s1_reg.xrel);
        s2_next.den    = s1_reg.dxa * fcsm_pkg::eff_step(cfg.speed_step);
    end

    // stage 3: dividend, never negative once the divisor is positive
    always_comb
    begin
        num_full       = $signed({1'b0, s2_reg.p_ya}) + $signed(s2_reg.p_dy);
        s3_next.direct = s2_reg.direct;
        s3_next.dval   = s2_reg.dval;
        s3_next.up     = s2_reg.up;
        s3_next.num    = num_full[fcsm_pkg::NUM_WIDTH-1:0];
        s3_next.den    = s2_reg.den;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (move1)
                s1_valid_reg <= sample.valid;
            if (move2)
                s2_valid_reg <= s1_valid_reg;
            if (move3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move1 && sample.valid)
            s1_reg <= s1_next;
        if (move2 && s1_valid_reg)
            s2_reg <= s2_next;
        if (move3 && s2_valid_reg)
            s3_reg <= s3_next;
    end

endmodule

// ===== src/fcsm_div.sv =====
// restoring divider, one quotient bit per pipeline stage
module fcsm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  fcsm_pkg::front_t  in_pl,
    output logic              in_ready,
    output logic              out_valid,
    output fcsm_pkg::div_t    out_pl,
    input  logic              out_ready
);

    logic                 stage_valid_reg [fcsm_pkg::SPEED_WIDTH];
    fcsm_pkg::div_stage_t stage_reg       [fcsm_pkg::SPEED_WIDTH];
    logic                 move            [fcsm_pkg::SPEED_WIDTH];

    genvar k;
    generate
        for (k = 0; k < fcsm_pkg::SPEED_WIDTH; k++)
        begin : g_stage
            localparam int BIT = fcsm_pkg::SPEED_WIDTH - 1 - k;

            fcsm_pkg::div_stage_t src, stage_next;
            logic                 src_valid;
            logic                 ge;
            logic [fcsm_pkg::NUM_WIDTH-1:0] rem_hi;

            if (k == 0)
            begin : g_head
                assign src_valid  = in_valid;
                assign src.direct = in_pl.direct;
                assign src.dval   = in_pl.dval;
                assign src.up     = in_pl.up;
                assign src.rem    = in_pl.num;
                assign src.den    = in_pl.den;
                assign src.quo    = '0;
            end
            else
            begin : g_body
                assign src_valid = stage_valid_reg[k-1];
                assign src       = stage_reg[k-1];
            end

            if (k == fcsm_pkg::SPEED_WIDTH - 1)
            begin : g_last
                assign move[k] = !stage_valid_reg[k] || out_ready;
            end
            else
            begin : g_mid
                assign move[k] = !stage_valid_reg[k] || move[k+1];
            end

            always_comb
            begin
                rem_hi     = src.rem >> BIT;
                ge         = rem_hi >= fcsm_pkg::NUM_WIDTH'(src.den);
                stage_next = src;
                if (ge)
                    stage_next.rem = src.rem - (fcsm_pkg::NUM_WIDTH'(src.den) << BIT);
                stage_next.quo[BIT] = ge;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    stage_valid_reg[k] <= 1'b0;
                else if (move[k])
                    stage_valid_reg[k] <= src_valid;
            end

            always_ff @(posedge clk)
            begin
                if (move[k] && src_valid)
                    stage_reg[k] <= stage_next;
            end
        end
    endgenerate

    assign in_ready       = move[0];
    assign out_valid      = stage_valid_reg[fcsm_pkg::SPEED_WIDTH-1];
    assign out_pl.direct  = stage_reg[fcsm_pkg::SPEED_WIDTH-1].direct;
    assign out_pl.dval    = stage_reg[fcsm_pkg::SPEED_WIDTH-1].dval;
    assign out_pl.up      = stage_reg[fcsm_pkg::SPEED_WIDTH-1].up;
    assign out_pl.rem_nz  = |stage_reg[fcsm_pkg::SPEED_WIDTH-1].rem;
    assign out_pl.quo     = stage_reg[fcsm_pkg::SPEED_WIDTH-1].quo;

endmodule

// ===== src/fcsm_back.sv =====
// rounding, rescale by the step and saturation: three pipeline stages
module fcsm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  fcsm_pkg::cfg_t  cfg,
    input  logic            in_valid,
    input  fcsm_pkg::div_t  in_pl,
    output logic            in_ready,
    fcsm_speed_if.source    speed
);

    typedef struct packed {
        logic                           direct;
        fcsm_pkg::speed_t               dval;
        logic [fcsm_pkg::SPEED_WIDTH:0] qf;
    } round_t;

    typedef struct packed {
        logic                             direct;
        fcsm_pkg::speed_t                 dval;
        logic [2*fcsm_pkg::SPEED_WIDTH:0] prod;
    } scale_t;

    logic b1_valid_reg, b2_valid_reg, b3_valid_reg;
    logic move1, move2, move3;
    round_t           b1_reg, b1_next;
    scale_t           b2_reg, b2_next;
    fcsm_pkg::speed_t b3_reg, b3_next;

    assign move3          = !b3_valid_reg || speed.ready;
    assign move2          = !b2_valid_reg || move3;
    assign move1          = !b1_valid_reg || move2;
    assign in_ready       = move1;
    assign speed.valid    = b3_valid_reg;
    assign speed.fan_speed = b3_reg;

    // round up only when a remainder is left and the up rule holds
    always_comb
    begin
        b1_next.direct = in_pl.direct;
        b1_next.dval   = in_pl.dval;
        b1_next.qf     = {1'b0, in_pl.quo}
                       + (fcsm_pkg::SPEED_WIDTH+1)'(in_pl.up & in_pl.rem_nz);
    end

    always_comb
    begin
        b2_next.direct = b1_reg.direct;
        b2_next.dval   = b1_reg.dval;
        b2_next.prod   = b1_reg.qf * fcsm_pkg::eff_step(cfg.speed_step);
    end

    always_comb
    begin
        if (b2_reg.direct)
            b3_next = b2_reg.dval;
        else if (b2_reg.prod > (2*fcsm_pkg::SPEED_WIDTH+1)'(fcsm_pkg::SPEED_MAX))
            b3_next = fcsm_pkg::SPEED_MAX;
        else
            b3_next = b2_reg.prod[fcsm_pkg::SPEED_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
        end
        else
        begin
            if (move1)
                b1_valid_reg <= in_valid;
            if (move2)
                b2_valid_reg <= b1_valid_reg;
            if (move3)
                b3_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move1 && in_valid)
            b1_reg <= b1_next;
        if (move2 && b1_valid_reg)
            b2_reg <= b2_next;
        if (move3 && b2_valid_reg)
            b3_reg <= b3_next;
    end

endmodule

// ===== src/fan_curve_speed_map.sv =====
// fan curve speed map: 22 register stages, 3 front, 16 divider, 3 back
// throughput: one temperature per cycle while the output is not stalled;
// the divider takes one quotient bit per stage
// each stage advances when empty or when its successor advances, so bubbles fill under stall
// reset clears all stage valid bits and loads register defaults (speed step 100, others 0)
module fan_curve_speed_map (
    input  logic          clk,
    input  logic          rst_n,
    fcsm_temp_if.sink     sample,
    fcsm_speed_if.source  speed,
    fcsm_cfg_if.sink      cfg
);

    fcsm_pkg::cfg_t   regs;
    logic             front_valid, front_ready;
    fcsm_pkg::front_t front_pl;
    logic             div_valid, div_ready;
    fcsm_pkg::div_t   div_pl;

    fcsm_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    fcsm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (regs),
        .sample    (sample),
        .out_valid (front_valid),
        .out_pl    (front_pl),
        .out_ready (front_ready)
    );

    fcsm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_pl     (front_pl),
        .in_ready  (front_ready),
        .out_valid (div_valid),
        .out_pl    (div_pl),
        .out_ready (div_ready)
    );

    fcsm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (regs),
        .in_valid (div_valid),
        .in_pl    (div_pl),
        .in_ready (div_ready),
        .speed    (speed)
    );

    // input is held off only when every stage is full and the output is stalled
    a_stall_only_from_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (speed.valid && !speed.ready)
    ) else $error("input stalled without output backpressure");

    // quotient of an interpolated item must fit the speed width
    a_quotient_fits: assert property (
        @(posedge clk) disable iff (!rst_n)
        (front_valid && !front_pl.direct) |->
            ((front_pl.num >> fcsm_pkg::SPEED_WIDTH) < fcsm_pkg::NUM_WIDTH'(front_pl.den))
    ) else $error("dividend out of range for the divider");

endmodule
